// File: rtl/skf_pkg.sv
package skf_pkg;

  localparam int unsigned DataW  = 32;
  localparam int unsigned CovW   = 31;
  localparam int unsigned GainW  = 17;
  localparam int unsigned QuoW   = 17;
  localparam int unsigned DenW   = 32;
  localparam int unsigned DivCntW = 5;
  localparam logic [GainW-1:0] GainOne = 17'd65536;
  localparam logic [GainW-1:0] HalfQ16 = 17'd32768;

  localparam logic [1:0] CfgProcNoise = 2'd0;
  localparam logic [1:0] CfgMeasNoise = 2'd1;
  localparam logic [1:0] CfgInitEst   = 2'd2;
  localparam logic [1:0] CfgInitCov   = 2'd3;

  typedef struct packed {
    logic load;
    logic prep;
    logic div_step;
    logic mul_est;
    logic finish;
  } skf_cmd_t;

  typedef struct packed {
    logic skip;
    logic div_last;
  } skf_sts_t;

endpackage

// File: rtl/scalar_kalman_filter_core.sv
// steps per request: load, prep, a radix-2 gain divider giving the 17-bit quotient a bit per step,
//   multiply and update; the divide, multiply and update are skipped when the error flag is set
//   or the divisor is zero; a new request is taken only after the previous result is accepted
// reset: synchronous active-low; configuration registers return to their default values,
//   estimate and covariance reset to those same defaults and the error clears
module scalar_kalman_filter_core
  import skf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [1:0]       cfg_index,
  input  logic [DataW-1:0] cfg_data,
  input  logic             in_valid,
  output logic             in_stall,
  input  logic [DataW-1:0] in_measurement,
  input  logic             in_restart,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [DataW-1:0] out_estimate,
  output logic [GainW-1:0] out_gain,
  output logic             out_numeric_error
);

  skf_cmd_t cmd;
  skf_sts_t sts;

  skf_ctrl u_ctrl (
    .clk, .rst_n, .in_valid, .in_stall, .out_valid, .out_stall, .sts, .cmd
  );

  skf_dp u_dp (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_meas(in_measurement), .in_restart, .cmd, .sts,
    .est_o(out_estimate), .gain_o(out_gain), .err_o(out_numeric_error)
  );

  a_gain_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_gain <= GainOne))
    else $error("gain above one");

  a_err_no_gain: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_numeric_error) |-> (out_gain == '0))
    else $error("gain reported with error set");

  a_busy_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input open while result pending");

endmodule

// File: rtl/skf_ctrl.sv
module skf_ctrl
  import skf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_stall,
  output logic     out_valid,
  input  logic     out_stall,
  input  skf_sts_t sts,
  output skf_cmd_t cmd
);

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_PREP = 6'b000010,
    S_DIV  = 6'b000100,
    S_MUL  = 6'b001000,
    S_FIN  = 6'b010000,
    S_OUT  = 6'b100000
  } state_t;

  state_t state_r, state_nxt;

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load = 1'b1;
          state_nxt = S_PREP;
        end
      end
      S_PREP: begin
        cmd.prep = 1'b1;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        if (sts.skip) begin
          cmd.finish = 1'b1;
          state_nxt = S_OUT;
        end else begin
          cmd.div_step = 1'b1;
          if (sts.div_last) state_nxt = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_est = 1'b1;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        cmd.finish = 1'b1;
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!out_stall) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else state_r <= state_nxt;
  end

endmodule

// File: rtl/skf_dp.sv
module skf_dp
  import skf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [1:0]        cfg_index,
  input  logic [DataW-1:0]  cfg_data,
  input  logic [DataW-1:0]  in_meas,
  input  logic              in_restart,
  input  skf_cmd_t          cmd,
  output skf_sts_t          sts,
  output logic [DataW-1:0]  est_o,
  output logic [GainW-1:0]  gain_o,
  output logic              err_o
);

  logic [CovW-1:0]    q_r, r_r, p0_r;
  logic [DataW-1:0]   x0_r;
  logic [DataW-1:0]   x_r, x_nxt;
  logic [CovW-1:0]    p_r, p_nxt;
  logic               err_r, err_nxt;
  logic [DataW-1:0]   meas_r;
  logic [CovW-1:0]    p1_r;
  logic [DenW-1:0]    den_r;
  logic [DenW:0]      rem_r;
  logic [QuoW-1:0]    quo_r;
  logic [DivCntW-1:0] cnt_r;
  logic               skip_r;
  logic [GainW-1:0]   gain_r;
  logic [DataW-1:0]   out_est_r;
  logic [GainW-1:0]   out_gain_r;
  logic               out_err_r;
  logic signed [50:0] prod_r;
  logic [47:0]        cprod_r;

  logic [CovW:0]      psum;
  logic [CovW-1:0]    p1_sat;
  logic [DenW:0]      rem_sh, rem_sub;
  logic               fits;
  logic [QuoW-1:0]    quo_nxt;
  logic [GainW-1:0]   k_fin;
  logic signed [DataW:0] diff;
  logic signed [50:0] prod;
  logic [47:0]        cprod;
  logic signed [34:0] delta;
  logic signed [34:0] xsum;
  logic [DataW-1:0]   xsat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      q_r  <= CovW'(6554);
      r_r  <= CovW'(6554);
      x0_r <= DataW'(327680);
      p0_r <= CovW'(6554);
    end else if (cfg_we) begin
      unique case (cfg_index)
        CfgProcNoise: q_r  <= cfg_data[CovW-1:0];
        CfgMeasNoise: r_r  <= cfg_data[CovW-1:0];
        CfgInitEst:   x0_r <= cfg_data;
        CfgInitCov:   p0_r <= cfg_data[CovW-1:0];
        default: ;
      endcase
    end
  end

  assign psum   = {1'b0, p_r} + {1'b0, q_r};
  assign p1_sat = psum[CovW] ? {CovW{1'b1}} : psum[CovW-1:0];

  assign fits    = (rem_r >= {1'b0, den_r});
  assign rem_sub = fits ? (rem_r - {1'b0, den_r}) : rem_r;
  assign rem_sh  = {rem_sub[DenW-1:0], 1'b0};
  assign quo_nxt = {quo_r[QuoW-2:0], fits};

  assign k_fin = (quo_r > GainOne) ? GainOne : quo_r;
  assign diff  = $signed({meas_r[DataW-1], meas_r}) - $signed({x_r[DataW-1], x_r});
  assign prod  = $signed({1'b0, k_fin}) * diff + 51'sd32768;
  assign cprod = 48'(GainOne - k_fin) * 48'(p1_r) + 48'(HalfQ16);
  assign delta = prod_r[50:16];
  assign xsum  = $signed({{3{x_r[DataW-1]}}, x_r}) + delta;
  assign xsat  = (xsum > 35'sd2147483647) ? 32'h7fffffff :
                 (xsum < -35'sd2147483648) ? 32'h80000000 : xsum[DataW-1:0];

  assign sts.skip     = skip_r;
  assign sts.div_last = (cnt_r == DivCntW'(QuoW - 1));

  always_comb begin
    x_nxt = x_r;
    p_nxt = p_r;
    err_nxt = err_r;
    if (cmd.load && in_restart) begin
      x_nxt = x0_r;
      p_nxt = p0_r;
      err_nxt = 1'b0;
    end
    if (cmd.prep && !err_r) begin
      p_nxt = p1_sat;
      if (({1'b0, p1_sat} + {1'b0, r_r}) == '0) err_nxt = 1'b1;
    end
    if (cmd.finish && !skip_r) begin
      x_nxt = xsat;
      p_nxt = cprod_r[46:16];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      x_r   <= DataW'(327680);
      p_r   <= CovW'(6554);
      err_r <= 1'b0;
    end else begin
      if (cmd.load && in_restart) begin
        x_r <= x0_r;
      end else begin
        x_r <= x_nxt;
      end
      p_r   <= p_nxt;
      err_r <= err_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) meas_r <= in_meas;
    if (cmd.prep) begin
      skip_r <= err_r || (({1'b0, p1_sat} + {1'b0, r_r}) == '0);
      p1_r   <= p1_sat;
      den_r  <= {1'b0, p1_sat} + {1'b0, r_r};
      rem_r  <= {2'b0, p1_sat};
      quo_r  <= '0;
      cnt_r  <= '0;
    end
    if (cmd.div_step) begin
      rem_r <= rem_sh;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + 1'b1;
    end
    if (cmd.mul_est) begin
      prod_r  <= prod;
      cprod_r <= cprod;
      gain_r  <= k_fin;
    end
    if (cmd.finish) begin
      out_est_r  <= skip_r ? x_r : xsat;
      out_gain_r <= skip_r ? '0 : gain_r;
      out_err_r  <= err_nxt;
    end
  end

  assign est_o  = out_est_r;
  assign gain_o = out_gain_r;
  assign err_o  = out_err_r;

endmodule

// File: tb/scalar_kalman_filter_core_test.sv
module scalar_kalman_filter_core_test;
  import skf_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint CovMax = 64'h7fff_ffff;
  localparam int unsigned TotalRequests = 1100;

  class kalman_scoreboard;
    typedef struct {
      logic [DataW-1:0] estimate;
      logic [GainW-1:0] gain;
      logic             numeric_error;
    } kalman_result_t;

    logic [CovW-1:0]         q_noise, r_noise, cov_init;
    logic signed [DataW-1:0] est_init;
    logic signed [DataW-1:0] est;
    logic [CovW-1:0]         cov;
    bit                      err;
    kalman_result_t          pending[$];
    int unsigned             mismatches, results, error_results;

    function void reload();
      est = est_init;
      cov = cov_init;
      err = 0;
    endfunction

    function void reset_state();
      q_noise  = 31'd6554;
      r_noise  = 31'd6554;
      est_init = 32'sd327680;
      cov_init = 31'd6554;
      reload();
    endfunction

    function void write_reg(logic [1:0] idx, logic [DataW-1:0] d);
      case (idx)
        CfgProcNoise: q_noise  = d[CovW-1:0];
        CfgMeasNoise: r_noise  = d[CovW-1:0];
        CfgInitEst:   est_init = d;
        CfgInitCov:   cov_init = d[CovW-1:0];
        default: ;
      endcase
    endfunction

    function void note_request(logic signed [DataW-1:0] m, bit rs);
      longint p1, den, diff, delta, nx, k;
      kalman_result_t r;
      k = 0;
      if (rs) reload();
      if (!err) begin
        p1 = longint'(cov) + longint'(q_noise);
        if (p1 > CovMax) p1 = CovMax;
        den = p1 + longint'(r_noise);
        cov = p1[CovW-1:0];
        if (den == 0) begin
          err = 1;
        end else begin
          k = (p1 <<< 16) / den;
          if (k > 65536) k = 65536;
          diff = longint'(m) - longint'(est);
          delta = (k * diff + 32768) >>> 16;
          nx = longint'(est) + delta;
          if (nx > 64'sh7fff_ffff) nx = 64'sh7fff_ffff;
          if (nx < -64'sh8000_0000) nx = -64'sh8000_0000;
          est = nx[DataW-1:0];
          cov = CovW'(((65536 - k) * p1 + 32768) >>> 16);
        end
      end
      r.estimate = est;
      r.gain = k[GainW-1:0];
      r.numeric_error = err;
      pending.push_back(r);
    endfunction

    function void check_result(logic [DataW-1:0] e, logic [GainW-1:0] g, logic ne);
      kalman_result_t x;
      results++;
      if (ne) error_results++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result est=%h gain=%h err=%b", e, g, ne);
      end else begin
        x = pending.pop_front();
        if (e !== x.estimate || g !== x.gain || ne !== x.numeric_error) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: est exp %h got %h, gain exp %h got %h, err exp %b got %b",
                     x.estimate, e, x.gain, g, x.numeric_error, ne);
        end
      end
    endfunction
  endclass

  logic             clk, rst_n;
  logic             cfg_we;
  logic [1:0]       cfg_index;
  logic [DataW-1:0] cfg_data;
  logic             in_valid, in_stall, in_restart;
  logic [DataW-1:0] in_measurement;
  logic             out_valid, out_stall, out_numeric_error;
  logic [DataW-1:0] out_estimate;
  logic [GainW-1:0] out_gain;

  kalman_scoreboard sb;
  int unsigned tx_pct, rx_pct, sent, restarts;

  scalar_kalman_filter_core u_dut (
    .clk(clk), .rst_n(rst_n),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_measurement(in_measurement), .in_restart(in_restart),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_estimate(out_estimate), .out_gain(out_gain),
    .out_numeric_error(out_numeric_error)
  );

  initial begin
    clk = 0;
    forever #10 clk = ~clk;
  end

  initial begin
    #15ms;
    $display("FAIL scalar_kalman_filter_core");
    $finish;
  end

  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_valid && !in_stall) sb.note_request(in_measurement, in_restart);
    if (rst_n && out_valid && !out_stall)
      sb.check_result(out_estimate, out_gain, out_numeric_error);
  end

  task automatic send_request(logic [DataW-1:0] m, bit rs);
    @(negedge clk);
    if ($urandom_range(99) < tx_pct) begin
      in_valid <= 0;
      do @(negedge clk); while ($urandom_range(99) < tx_pct);
    end
    in_valid <= 1;
    in_measurement <= m;
    in_restart <= rs;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sent++;
    if (rs) restarts++;
    tx_pct = (sent < TotalRequests / 3) ? 21 : (sent < 2 * TotalRequests / 3) ? 74 : 0;
    rx_pct = (sent < TotalRequests / 3) ? 74 : (sent < 2 * TotalRequests / 3) ? 21 : 0;
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
  endtask

  task automatic set_config(logic [DataW-1:0] q, logic [DataW-1:0] r,
                            logic [DataW-1:0] x0, logic [DataW-1:0] p0);
    logic [DataW-1:0] vals[4];
    vals = '{q, r, x0, p0};
    drain();
    for (int i = 0; i < 4; i++) begin
      @(negedge clk);
      cfg_we <= 1;
      cfg_index <= i[1:0];
      cfg_data <= vals[i];
      sb.write_reg(i[1:0], vals[i]);
    end
    @(negedge clk);
    cfg_we <= 0;
  endtask

  function automatic logic [DataW-1:0] pick_noise(int unsigned kind);
    case ($urandom_range(3))
      0: return (kind == 2) ? 32'h0 : $urandom;
      1: return $urandom_range(0, 1 << 20);
      2: return (kind == 2) ? 32'h0 : 32'hffff_ffff;
      default: return (kind == 1) ? 32'h7fff_ffff : 32'h0;
    endcase
  endfunction

  function automatic logic [DataW-1:0] pick_measurement();
    int unsigned c;
    c = $urandom_range(99);
    if (c < 50) return sb.est + ($signed($urandom) >>> $urandom_range(8, 24));
    if (c < 80) return $urandom;
    case ($urandom_range(3))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return 32'h0;
      default: return 32'hffff_ffff;
    endcase
  endfunction

  initial begin
    int unsigned kind, n;
    sb = new();
    sb.reset_state();
    rst_n = 0;
    cfg_we = 0; cfg_index = '0; cfg_data = '0;
    in_valid = 0; in_measurement = '0; in_restart = 0;
    tx_pct = 21; rx_pct = 74;
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;

    send_request(32'h7fff_ffff, 0);
    send_request(32'h8000_0000, 0);
    send_request(32'h0, 1);
    send_request(32'hffff_ffff, 0);
    send_request(32'h1, 0);
    set_config(32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff);
    send_request(32'h7fff_ffff, 1);
    send_request(32'h8000_0000, 0);
    send_request(32'h0, 0);
    set_config(32'h0, 32'h8000_0000, 32'h7fff_ffff, 32'h0001_0000);
    send_request(32'h8000_0000, 1);
    send_request(32'h7fff_ffff, 0);
    set_config(32'h0, 32'h0, 32'd12345, 32'h8000_0000);
    send_request(32'd5, 1);
    send_request(32'd7, 0);
    send_request(32'd9, 1);
    set_config(32'd6554, 32'h0, 32'h0, 32'h0);
    send_request(32'd100, 1);
    send_request(32'hffff_0000, 0);

    for (int ph = 0; sent < TotalRequests; ph++) begin
      kind = $urandom_range(3);
      set_config(pick_noise(kind), pick_noise(kind),
                 ($urandom_range(3) == 0) ? 32'h8000_0000 : $urandom, pick_noise(kind));
      n = $urandom_range(20, 80);
      for (int i = 0; i < n; i++) begin
        if (ph == 5 && i == 20) drain();
        send_request(pick_measurement(), (i == 0) || ($urandom_range(99) < 6));
      end
    end

    drain();
    $display("%0d requests (%0d with restart), %0d results, %0d flagged numeric error",
             sent, restarts, sb.results, sb.error_results);
    if (sb.mismatches == 0 && sb.pending.size() == 0) begin
      $display("PASS scalar_kalman_filter_core");
    end else begin
      $display("FAIL scalar_kalman_filter_core");
    end
    $finish;
  end

endmodule

// File: scalar_kalman_filter_core.f
rtl/skf_pkg.sv
rtl/skf_ctrl.sv
rtl/skf_dp.sv
rtl/scalar_kalman_filter_core.sv
tb/scalar_kalman_filter_core_test.sv
